FILE: src/shift_or_last_occurrence_search_unit_defines.svh
// assertion helpers shared by the checker
`ifndef SHIFT_OR_LAST_OCCURRENCE_SEARCH_UNIT_DEFINES_SVH
`define SHIFT_OR_LAST_OCCURRENCE_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SOLS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sols check failed");

// next-cycle implication, clocked on clk, off during reset
`define SOLS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sols check failed");

`endif

FILE: src/sols_pkg.sv
`timescale 1ns / 1ps
package sols_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int BYTE_W = 8;
	localparam int POS_W = 16;

	typedef logic [MAX_PATTERN-1:0] vec_t;
	typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_t;
	typedef logic [LEN_W-1:0] len_t;

	typedef enum logic {
		CMD_PATTERN = 1'b0,
		CMD_TEXT    = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_EMPTY    = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_t;

	// outcome of one shift-or step
	typedef struct packed {
		logic hit;
		vec_t vec;
	} scan_t;

endpackage

FILE: src/sols_match.sv
`timescale 1ns / 1ps
module sols_match import sols_pkg::*; (
	input  pat_t              pat,
	input  len_t              pattern_length,
	input  vec_t              vec_in,
	input  logic [BYTE_W-1:0] text_byte,
	output scan_t             scan
);

	vec_t cmp;
	vec_t vec;
	len_t len_m1;

	// pat[k] holds pattern byte (len-1-k), newest byte at index 0
	always_comb begin
		cmp = '1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if ((LEN_W'(k) < pattern_length) && (pat[k] == text_byte)) begin
				cmp[k] = 1'b0;
			end
		end
		vec = (vec_in << 1) | cmp;
		len_m1 = pattern_length - len_t'(1);
		scan.vec = vec;
		scan.hit = !vec[len_m1[IDX_W-1:0]];
	end

endmodule

FILE: src/shift_or_last_occurrence_search_unit.sv
`timescale 1ns / 1ps
// Last-occurrence search by shift-or. Load the pattern one beat per byte with
// cmd 0 (start_req on its first byte), then feed the text last byte first with
// cmd 1 (start_req on the first text beat). Every accepted beat gives one
// result beat: found, the zero-based start of the last occurrence (0 until
// found), and an error code. The block takes one beat per cycle while results
// are taken; a beat is held in the input register, where the parallel compare
// against all stored pattern bytes and the shift-or update run, and then sits
// in the output register until taken.
module shift_or_last_occurrence_search_unit import sols_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [BYTE_W-1:0] byte_value,
	input  logic [POS_W-1:0]  position,
	input  logic              start_req,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic [POS_W-1:0]  match_position,
	output logic [1:0]        error
);

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              start_s1;

	pat_t             pat_q;
	len_t             len_q;
	logic             ovf_q;
	vec_t             vec_q;
	logic             found_q;
	logic [POS_W-1:0] fpos_q;

	len_t             len_n;
	len_t             base_len;
	logic             ovf_n;
	vec_t             vec_n;
	logic             found_n;
	logic [POS_W-1:0] fpos_n;
	logic             shift_en;
	err_t             err_n;
	vec_t             vec_base;
	logic             found_base;
	scan_t            scan;
	logic             advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= cmd_t'(cmd);
			byte_s1  <= byte_value;
			pos_s1   <= position;
			start_s1 <= start_req;
		end
	end

	// a text start clears the scan before the byte is searched
	assign vec_base   = start_s1 ? '1 : vec_q;
	assign found_base = start_s1 ? 1'b0 : found_q;

	sols_match u_match (
		.pat            (pat_q),
		.pattern_length (len_q),
		.vec_in         (vec_base),
		.text_byte      (byte_s1),
		.scan           (scan)
	);

	always_comb begin
		len_n    = len_q;
		ovf_n    = ovf_q;
		vec_n    = vec_q;
		found_n  = found_q;
		fpos_n   = fpos_q;
		shift_en = 1'b0;
		err_n    = ERR_NONE;
		base_len = start_s1 ? '0 : len_q;
		case (cmd_s1)
			CMD_PATTERN: begin
				if (start_s1) begin
					ovf_n   = 1'b0;
					vec_n   = '1;
					found_n = 1'b0;
					fpos_n  = '0;
				end
				if (base_len < LEN_W'(MAX_PATTERN)) begin
					shift_en = 1'b1;
					len_n    = base_len + len_t'(1);
				end else begin
					ovf_n = 1'b1;
				end
			end
			CMD_TEXT: begin
				vec_n   = vec_base;
				found_n = found_base;
				if (start_s1) begin
					fpos_n = '0;
				end
				if (len_q == '0) begin
					err_n = ERR_EMPTY;
				end else if (!ovf_q && !found_base) begin
					vec_n = scan.vec;
					if (scan.hit) begin
						found_n = 1'b1;
						fpos_n  = pos_s1;
					end
				end
			end
			default: begin
				err_n = ERR_NONE;
			end
		endcase
		if (ovf_n) begin
			err_n = ERR_OVERFLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			vec_q   <= '1;
			found_q <= 1'b0;
			fpos_q  <= '0;
		end else if (advance) begin
			len_q   <= len_n;
			ovf_q   <= ovf_n;
			vec_q   <= vec_n;
			found_q <= found_n;
			fpos_q  <= fpos_n;
		end
	end

	// pattern store is a shift line, newest byte at the bottom
	always_ff @(posedge clk) begin
		if (advance && shift_en) begin
			pat_q[0] <= byte_s1;
			for (int k = 1; k < MAX_PATTERN; k++) begin
				pat_q[k] <= pat_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found          <= found_n;
			match_position <= fpos_n;
			error          <= err_n;
		end
	end

endmodule

FILE: src/sols_checker.sv
`timescale 1ns / 1ps
`include "shift_or_last_occurrence_search_unit_defines.svh"
module sols_checker import sols_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             found,
	input logic [POS_W-1:0] match_position,
	input logic [1:0]       error
);

	`SOLS_ASSERT_NOW(a_pos_zero_unless_found, out_valid && !found, match_position == '0)
	`SOLS_ASSERT_NOW(a_error_code_legal, out_valid, error != 2'd3)
	`SOLS_ASSERT_NOW(a_overflow_hides_empty, out_valid && (error == ERR_EMPTY), !found)
	`SOLS_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable(error))

endmodule

bind shift_or_last_occurrence_search_unit sols_checker u_sols_checker (.*);
